### rtl/kped_pkg.sv
// Package: shared types and constants for the key press event detector.
`timescale 1ns / 1ps

package kped_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned RptW   = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [HoldW-1:0] HOLD_MAX = {HoldW{1'b1}};

  localparam logic [15:0]     LONG_TICKS_RST = 16'd100;
  localparam logic [15:0]     DELAY_TICKS_RST = 16'd50;
  localparam logic [RptW-1:0] INTERVAL_TICKS_RST = 4'd10;
  localparam logic [KeyW-1:0] REPEAT_KEY_FIRST_RST = 16'd8;
  localparam logic [KeyW-1:0] REPEAT_KEY_SECOND_RST = 16'd128;

  localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_KEY_FIRST = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_KEY_SECOND = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_RELEASE = 3'd2,
    PH_CHANGE  = 3'd3,
    PH_REPEAT  = 3'd4
  } phase_t;

  typedef enum logic [KindW-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [15:0]     long_ticks;
    logic [15:0]     delay_ticks;
    logic [RptW-1:0] interval_ticks;
    logic [KeyW-1:0] repeat_key_first;
    logic [KeyW-1:0] repeat_key_second;
  } cfg_t;

  typedef struct packed {
    event_kind_t     kind;
    logic [KeyW-1:0] key;
  } event_t;

endpackage

### rtl/kped_cfg.sv
// Configuration registers of the key press event detector.
`timescale 1ns / 1ps

module kped_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kped_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kped_pkg::CfgDataW-1:0] cfg_wdata,
  output kped_pkg::cfg_t                cfg
);

  kped_pkg::cfg_t cfg_r;
  kped_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        kped_pkg::CFG_LONG_TICKS:        cfg_nxt.long_ticks = cfg_wdata;
        kped_pkg::CFG_DELAY_TICKS:       cfg_nxt.delay_ticks = cfg_wdata;
        kped_pkg::CFG_INTERVAL_TICKS:
          cfg_nxt.interval_ticks = cfg_wdata[kped_pkg::RptW-1:0];
        kped_pkg::CFG_REPEAT_KEY_FIRST:  cfg_nxt.repeat_key_first = cfg_wdata;
        kped_pkg::CFG_REPEAT_KEY_SECOND: cfg_nxt.repeat_key_second = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks        <= kped_pkg::LONG_TICKS_RST;
      cfg_r.delay_ticks       <= kped_pkg::DELAY_TICKS_RST;
      cfg_r.interval_ticks    <= kped_pkg::INTERVAL_TICKS_RST;
      cfg_r.repeat_key_first  <= kped_pkg::REPEAT_KEY_FIRST_RST;
      cfg_r.repeat_key_second <= kped_pkg::REPEAT_KEY_SECOND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/kped_fsm.sv
// Key tracking state machine: phase, held key and hold and repeat counters.
`timescale 1ns / 1ps

module kped_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [kped_pkg::KeyW-1:0]   key,
  input  kped_pkg::cfg_t              cfg,
  output kped_pkg::event_t            evt
);

  kped_pkg::phase_t                 phase_r, phase_nxt;
  logic [kped_pkg::KeyW-1:0]        held_key_r, held_key_nxt;
  logic [kped_pkg::HoldW-1:0]       hold_count_r, hold_count_nxt;
  logic [kped_pkg::RptW-1:0]        repeat_count_r, repeat_count_nxt;

  logic                             same;
  logic                             is_repeat_key;
  logic [kped_pkg::HoldW-1:0]       hold_inc;
  logic [kped_pkg::RptW-1:0]        rpt_inc;
  logic                             long_hit;
  logic                             delay_hit;
  logic                             interval_hit;

  assign same          = (key == held_key_r);
  assign is_repeat_key = (key == cfg.repeat_key_first) || (key == cfg.repeat_key_second);
  assign hold_inc      = (hold_count_r != kped_pkg::HOLD_MAX) ?
                         hold_count_r + kped_pkg::HoldW'(1) : hold_count_r;
  assign rpt_inc       = repeat_count_r + kped_pkg::RptW'(1);
  assign long_hit      = (hold_inc >= cfg.long_ticks);
  assign delay_hit     = (hold_inc >= cfg.delay_ticks);
  assign interval_hit  = (rpt_inc >= cfg.interval_ticks);

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    held_key_nxt     = held_key_r;
    hold_count_nxt   = hold_count_r;
    repeat_count_nxt = repeat_count_r;
    case (phase_r)
      kped_pkg::PH_CONFIRM: begin
        if (same) begin
          if (key[0]) begin
            phase_nxt = kped_pkg::PH_RELEASE;
          end else if (is_repeat_key) begin
            phase_nxt = kped_pkg::PH_REPEAT;
          end else begin
            phase_nxt = kped_pkg::PH_CHANGE;
          end
        end else begin
          phase_nxt = kped_pkg::PH_IDLE;
        end
      end
      kped_pkg::PH_RELEASE: begin
        if (!same) begin
          phase_nxt      = kped_pkg::PH_IDLE;
          hold_count_nxt = '0;
        end else if (long_hit) begin
          phase_nxt      = kped_pkg::PH_CHANGE;
          hold_count_nxt = '0;
        end else begin
          hold_count_nxt = hold_inc;
        end
      end
      kped_pkg::PH_CHANGE: begin
        if (!same) begin
          phase_nxt = kped_pkg::PH_IDLE;
        end
      end
      kped_pkg::PH_REPEAT: begin
        if (same) begin
          hold_count_nxt = hold_inc;
          if (delay_hit) begin
            repeat_count_nxt = interval_hit ? '0 : rpt_inc;
          end
        end else begin
          hold_count_nxt = '0;
          phase_nxt      = kped_pkg::PH_CHANGE;
        end
      end
      default: begin
        if (key != '0) begin
          held_key_nxt = key;
          phase_nxt    = kped_pkg::PH_CONFIRM;
        end else begin
          phase_nxt    = kped_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // event output
  always_comb begin
    evt.kind = kped_pkg::EV_NONE;
    evt.key  = '0;
    case (phase_r)
      kped_pkg::PH_CONFIRM: begin
        if (same) begin
          evt.kind = kped_pkg::EV_PRESS;
          evt.key  = held_key_r;
        end
      end
      kped_pkg::PH_RELEASE: begin
        if (!same) begin
          evt.kind = kped_pkg::EV_RELEASE;
          evt.key  = held_key_r;
        end else if (long_hit) begin
          evt.kind = kped_pkg::EV_LONG;
          evt.key  = key;
        end
      end
      kped_pkg::PH_REPEAT: begin
        if (same && delay_hit && interval_hit) begin
          evt.kind = kped_pkg::EV_REPEAT;
          evt.key  = key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= kped_pkg::PH_IDLE;
      held_key_r     <= '0;
      hold_count_r   <= '0;
      repeat_count_r <= '0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      held_key_r     <= held_key_nxt;
      hold_count_r   <= hold_count_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

endmodule

### rtl/key_press_event_detector_core.sv
// Top level of the key press event detector: input and result registers around the state machine.
// An accepted item goes through the input register, then the result register, to the out_ ports.
// Throughput: one item per cycle while out_stall is low; the input register and the result register
// let a new item enter while a finished result waits on a stalled output.
// Reset (synchronous, rst_n low): phase idle, counters and held key cleared,
// configuration back to its defaults, both registers empty.
`timescale 1ns / 1ps

module key_press_event_detector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kped_pkg::KeyW-1:0]     in_key_bitmap,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kped_pkg::KindW-1:0]    out_event_kind,
  output logic [kped_pkg::KeyW-1:0]     out_event_key,
  input  logic                          cfg_wr_en,
  input  logic [kped_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kped_pkg::CfgDataW-1:0] cfg_wdata
);

  logic                         in_vld_r, in_vld_nxt;
  logic [kped_pkg::KeyW-1:0]    in_key_r;
  logic                         out_vld_r, out_vld_nxt;
  logic [kped_pkg::KindW-1:0]   out_kind_r;
  logic [kped_pkg::KeyW-1:0]    out_key_r;
  logic                         in_take;
  logic                         adv;
  kped_pkg::cfg_t               cfg;
  kped_pkg::event_t             evt;

  kped_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kped_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .key   (in_key_r),
    .cfg   (cfg),
    .evt   (evt)
  );

  // advance the held item into the result register when it is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_key_r <= in_key_bitmap;
    end
    if (adv) begin
      out_kind_r <= evt.kind;
      out_key_r  <= evt.key;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_event_key  = out_key_r;

endmodule
